>>> design/emb_pkg.sv
package emb_pkg;

   // transaction opcodes
   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2
   } opcode_type;

   // per-cycle controls broadcast to every cell of the chain
   typedef struct packed {
      logic clear;
      logic shift_pattern;
      logic shift_text;
   } emb_ctrl_type;

endpackage

>>> design/emb_cell.sv
module emb_cell
   import emb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  emb_ctrl_type ctrl,
   input  logic [7:0]   prev_pat_byte,
   input  logic         prev_pat_valid,
   input  logic [7:0]   prev_win_byte,
   input  logic         prev_win_valid,
   output logic [7:0]   pat_byte,
   output logic         pat_valid,
   output logic [7:0]   win_byte,
   output logic         win_valid,
   output logic         match_ok
);

   logic [7:0] pat_byte_ff, pat_byte_in;
   logic       pat_valid_ff, pat_valid_in;
   logic [7:0] win_byte_ff, win_byte_in;
   logic       win_valid_ff, win_valid_in;

   // next state: clear on a new search, otherwise shift from the neighbor
   always_comb begin
      pat_byte_in  = pat_byte_ff;
      pat_valid_in = pat_valid_ff;
      win_byte_in  = win_byte_ff;
      win_valid_in = win_valid_ff;
      if (ctrl.clear) begin
         pat_valid_in = 1'b0;
         win_valid_in = 1'b0;
      end else begin
         if (ctrl.shift_pattern) begin
            pat_byte_in  = prev_pat_byte;
            pat_valid_in = prev_pat_valid;
         end
         if (ctrl.shift_text) begin
            win_byte_in  = prev_win_byte;
            win_valid_in = prev_win_valid;
         end
      end
   end

   // control bits reset, payload bytes do not
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_valid_ff <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         pat_valid_ff <= pat_valid_in;
         win_valid_ff <= win_valid_in;
      end
      pat_byte_ff <= pat_byte_in;
      win_byte_ff <= win_byte_in;
   end

   // compare the pattern byte with the window byte arriving this cycle
   assign match_ok  = !pat_valid_ff || (prev_win_valid && (pat_byte_ff == prev_win_byte));

   assign pat_byte  = pat_byte_ff;
   assign pat_valid = pat_valid_ff;
   assign win_byte  = win_byte_ff;
   assign win_valid = win_valid_ff;

endmodule

>>> design/exact_byte_pattern_matcher_core.sv
// Exact byte pattern matcher: reports every text offset where the pattern starts.
// Request channel (req_valid/req_ready) carries an opcode and a data byte:
//   OP_BEGIN starts a new search, OP_APPEND adds one pattern byte,
//   OP_TEXT feeds one text byte; opcode three is ignored.
// The pattern and the text window live in a chain of MAX_PATTERN cells; each
// cell holds one pattern byte and one window byte and compares them in parallel.
// A text transaction that completes a match produces one response transaction
// (rsp_valid/rsp_ready) carrying the zero-based start offset in rsp_hit_position.
// The response is registered and is valid the cycle after the matching text byte is taken.
// Throughput: one request per cycle unless a response is stalled, set by the
// parallel compare and AND tree across the cell chain.
// Appending past MAX_PATTERN bytes sets an overflow flag that suppresses hits
// until the next new search. An empty pattern gives no hits.
// Reset (synchronous, active high) empties the pattern, the window and the
// offset counter. When the receiver stalls with a response pending, req_ready
// drops until the response is taken; a pending response is never overwritten.
module exact_byte_pattern_matcher_core
   import emb_pkg::*;
#(
   parameter int MAX_PATTERN   = 32,
   parameter int POSITION_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hit_position
);

   localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

   logic                     req_fire;
   logic                     full;
   logic                     hit;
   emb_ctrl_type             ctrl;
   logic [LEN_BITS-1:0]      len_ff, len_in;
   logic                     overflow_ff, overflow_in;
   logic [POSITION_BITS-1:0] count_ff, count_in;
   logic [POSITION_BITS-1:0] start_pos;
   logic [POSITION_BITS+31:0] start_ext;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              rsp_hit_position_ff, rsp_hit_position_in;

   logic [7:0]             pat_byte  [MAX_PATTERN];
   logic [7:0]             win_byte  [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] pat_valid;
   logic [MAX_PATTERN-1:0] win_valid;
   logic [MAX_PATTERN-1:0] match_ok;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = pat_valid[MAX_PATTERN-1];

   // decode the transaction into chain controls
   always_comb begin
      ctrl.clear         = req_fire && (req_opcode == OP_BEGIN);
      ctrl.shift_pattern = req_fire && (req_opcode == OP_APPEND) && !overflow_ff && !full;
      ctrl.shift_text    = req_fire && (req_opcode == OP_TEXT);
   end

   // chain of cells, newest bytes enter at cell zero
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      if (j == 0) begin : g_head
         emb_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctrl           (ctrl),
            .prev_pat_byte  (req_data_byte),
            .prev_pat_valid (1'b1),
            .prev_win_byte  (req_data_byte),
            .prev_win_valid (1'b1),
            .pat_byte       (pat_byte[j]),
            .pat_valid      (pat_valid[j]),
            .win_byte       (win_byte[j]),
            .win_valid      (win_valid[j]),
            .match_ok       (match_ok[j])
         );
      end else begin : g_body
         emb_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctrl           (ctrl),
            .prev_pat_byte  (pat_byte[j-1]),
            .prev_pat_valid (pat_valid[j-1]),
            .prev_win_byte  (win_byte[j-1]),
            .prev_win_valid (win_valid[j-1]),
            .pat_byte       (pat_byte[j]),
            .pat_valid      (pat_valid[j]),
            .win_byte       (win_byte[j]),
            .win_valid      (win_valid[j]),
            .match_ok       (match_ok[j])
         );
      end
   end

   // pattern length, overflow flag and text offset
   always_comb begin
      len_in      = len_ff;
      overflow_in = overflow_ff;
      count_in    = count_ff;
      if (ctrl.clear) begin
         len_in      = '0;
         overflow_in = 1'b0;
         count_in    = '0;
      end else begin
         if (ctrl.shift_pattern) begin
            len_in = len_ff + 1'b1;
         end
         if (req_fire && (req_opcode == OP_APPEND) && !overflow_ff && full) begin
            overflow_in = 1'b1;
         end
         if (ctrl.shift_text) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // hit detection against the window as it stands after this byte
   assign hit       = ctrl.shift_text && !overflow_ff && pat_valid[0] && (&match_ok);
   assign start_pos = count_in - {{(POSITION_BITS-LEN_BITS){1'b0}}, len_ff};
   assign start_ext = {32'd0, start_pos};

   // output register
   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_hit_position_in = rsp_hit_position_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (hit) begin
         rsp_valid_in        = 1'b1;
         rsp_hit_position_in = start_ext[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         overflow_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         overflow_ff  <= overflow_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_position_ff <= rsp_hit_position_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_position = rsp_hit_position_ff;

   // length counter tracks the pattern valid bits in the chain
   a_len_matches_chain: assert property (@(posedge clock) disable iff (reset)
      len_ff == LEN_BITS'($countones(pat_valid)))
      else $error("pattern length out of step with cell chain");

   // overflow only with a full pattern
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> full)
      else $error("overflow flag set without full pattern");

   // a new response only follows a text transaction
   a_rsp_from_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |->
         $past(req_fire && (req_opcode == OP_TEXT)))
      else $error("response without text transaction");

   // a new search empties the pattern
   a_begin_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (len_ff == '0) && !overflow_ff && (pat_valid == '0))
      else $error("new search did not clear pattern");

endmodule
